### hw/rtl/double_ended_queue_assert.svh
// Assertion helpers for the deque; clk and rst_n are taken from the enclosing module.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    FN_PUSH_REAR,
    FN_PUSH_FRONT,
    FN_POP_FRONT,
    FN_POP_REAR
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_EMPTY,
    ST_FULL
  } status_t;

  // one strobe per operation, raised only when the operation goes through
  typedef struct packed {
    logic push_rear;
    logic push_front;
    logic pop_front;
    logic pop_rear;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/double_ended_queue.sv
`default_nettype none
// Bounded deque of DEPTH signed 32-bit words built as a row of cells, the front word always in
// cell 0. in_tuser selects push rear, push front, pop front or pop rear; every beat in gives one
// beat out carrying the popped word (zero on a push or a failed pop), a status (done, pop on
// empty, push on full) and the occupancy afterwards. On each operation the cells
// shift towards or away from the front, or the cell at the end of the occupied run is written or
// released, all at the accepting edge, and the result sits in an output register. A new beat is
// taken in the cycle the previous result is taken, so with a ready sink the block runs at one
// beat per cycle. Failed operations leave the contents untouched. No clearing pass after reset.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] pop_value, [36:32] occupancy, zero fill above
  output logic      [1:0]  out_tuser   // [1:0] status
);
  import dq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] pop_value_r, pop_value_nxt;
  status_t           status_r, status_nxt;
  logic [OCC_W-1:0]  occ_out_r;

  logic              in_accept;
  func_t             func;
  cell_ctl_t         ctl;
  logic              full, empty;
  logic [WORD_W-1:0] rear_value;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_occ;
  logic [WORD_W-1:0] cell_rear [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);
  assign empty     = !cell_occ[0];
  assign full      = cell_occ[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_word  (in_tdata),
      .left_data  ((i == 0) ? in_tdata : cell_data[(i == 0) ? 0 : i-1]),
      .left_occ   ((i == 0) ? 1'b1 : cell_occ[(i == 0) ? 0 : i-1]),
      .right_data ((i == DEPTH-1) ? '0 : cell_data[(i == DEPTH-1) ? i : i+1]),
      .right_occ  ((i == DEPTH-1) ? 1'b0 : cell_occ[(i == DEPTH-1) ? i : i+1]),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .rear_word  (cell_rear[i])
    );
  end

  // only one cell drives a non-zero rear word
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_rear[i];
    end
  end

  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    pop_value_nxt = pop_value_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      pop_value_nxt = '0;
      status_nxt    = ST_DONE;
      case (func)
        FN_PUSH_REAR, FN_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctl.push_rear  = (func == FN_PUSH_REAR);
            ctl.push_front = (func == FN_PUSH_FRONT);
            count_nxt      = count_r + 1'b1;
          end
        end
        FN_POP_FRONT, FN_POP_REAR: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctl.pop_front = (func == FN_POP_FRONT);
            ctl.pop_rear  = (func == FN_POP_REAR);
            pop_value_nxt = (func == FN_POP_FRONT) ? cell_data[0] : rear_value;
            count_nxt     = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_value_r <= pop_value_nxt;
    status_r    <= status_nxt;
    if (in_accept) begin
      occ_out_r <= OCC_W'(32'(count_nxt));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, occ_out_r, pop_value_r};
  assign out_tuser  = status_r;

`include "double_ended_queue_assert.svh"

  `DQ_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(cell_occ) == 32'(count_r), "count and occupied cells disagree")
  `DQ_ASSERT_NOW(a_failed_pop_zero, out_valid_r && status_r == ST_EMPTY, pop_value_r == '0, "failed pop carries a word")
  `DQ_ASSERT_NEXT(a_push_front_lands, in_accept && func == FN_PUSH_FRONT && !full, cell_data[0] == $past(in_tdata) && cell_occ[0], "push front did not reach cell 0")
  `DQ_ASSERT_NOW(a_result_from_beat, $rose(out_valid_r), $past(in_accept), "result without an input beat")

endmodule
`default_nettype wire

### hw/rtl/dq_cell.sv
`default_nettype none
module dq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_pkg::cell_ctl_t          ctl,
  input  wire logic [dq_pkg::WORD_W-1:0]  push_word,
  input  wire logic [dq_pkg::WORD_W-1:0]  left_data,
  input  wire logic                       left_occ,
  input  wire logic [dq_pkg::WORD_W-1:0]  right_data,
  input  wire logic                       right_occ,
  output logic      [dq_pkg::WORD_W-1:0]  data,
  output logic                            occ,
  output logic      [dq_pkg::WORD_W-1:0]  rear_word
);
  import dq_pkg::*;

  logic [WORD_W-1:0] data_r, data_nxt;
  logic              occ_r, occ_nxt;
  logic              is_rear;

  // the rear word sits where the occupied run ends
  assign is_rear = occ_r && !right_occ;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (ctl.push_front) begin
      data_nxt = left_data;
      occ_nxt  = left_occ;
    end else if (ctl.pop_front) begin
      data_nxt = right_data;
      occ_nxt  = right_occ;
    end else if (ctl.push_rear) begin
      if (!occ_r && left_occ) begin
        data_nxt = push_word;
        occ_nxt  = 1'b1;
      end
    end else if (ctl.pop_rear) begin
      if (is_rear) begin
        occ_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign occ       = occ_r;
  assign rear_word = is_rear ? data_r : '0;

endmodule
`default_nettype wire
